[hw/rtl/mdks_pkg.sv]
// Shared types and constants of the display and key scanner.
package mdks_pkg;

  localparam int unsigned DIGITS   = 4;
  localparam int unsigned DIG_W    = $clog2(DIGITS);
  localparam int unsigned SEG_W    = 8;
  localparam int unsigned NIB_W    = 4;
  localparam int unsigned REF_W    = 8;
  localparam int unsigned SCAN_W   = 16;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned STEP_W   = 3;

  localparam logic [REF_W-1:0]  REFRESH_RESET = 8'd5;
  localparam logic [SCAN_W-1:0] SCAN_RESET    = 16'd50;
  localparam logic [NIB_W-1:0]  ROW_LAST      = 4'b1000;
  localparam logic [NIB_W-1:0]  ONE_NIB       = 4'b0001;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_WRITE = 1'b1
  } opcode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REFRESH_PERIOD = 1'b0,
    CFG_SCAN_PERIOD    = 1'b1
  } cfg_idx_e;

  // Classified item handed from front to back.
  typedef struct packed {
    logic              refresh;
    logic              scan;
    logic [NIB_W-1:0]  dig_nib;
    logic [NIB_W-1:0]  row_nib;
    logic [SEG_W-1:0]  seg;
    logic [NIB_W-1:0]  rise;
    logic [NIB_W-1:0]  fall;
  } cmd_t;

endpackage

[hw/rtl/mdks_if.sv]
// Valid/ready channel interfaces for input and result items.
interface mdks_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [3:0] key_levels;
  logic [1:0] digit_index;
  logic [7:0] segment_pattern;

  modport source (output valid, opcode, key_levels, digit_index, segment_pattern,
                  input ready);
  modport sink   (input valid, opcode, key_levels, digit_index, segment_pattern,
                  output ready);
endinterface

interface mdks_out_if;
  logic       valid;
  logic       ready;
  logic       frame_valid;
  logic [7:0] select_byte;
  logic [7:0] segment_byte;
  logic       last;
  logic [3:0] key_rise;
  logic [3:0] key_fall;

  modport source (output valid, frame_valid, select_byte, segment_byte, last,
                  key_rise, key_fall, input ready);
  modport sink   (input valid, frame_valid, select_byte, segment_byte, last,
                  key_rise, key_fall, output ready);
endinterface

[hw/rtl/mdks_front.sv]
// Front end: accepts items, keeps counters, pattern store and key flags.
module mdks_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  mdks_in_if.sink                             in_i,
  input  logic                                cfg_we_i,
  input  logic [mdks_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [mdks_pkg::CFG_W-1:0]          cfg_data_i,
  input  logic                                q_ready_i,
  output logic                                q_push_o,
  output mdks_pkg::cmd_t                      q_cmd_o
);
  import mdks_pkg::*;

  logic [REF_W-1:0]  refresh_period_q;
  logic [SCAN_W-1:0] scan_period_q;
  logic [DIG_W-1:0]  digit_turn_q, digit_turn_d;
  logic [SEG_W-1:0]  sel_q, sel_d;
  logic [SEG_W-1:0]  seg_q, seg_d;
  logic [SEG_W-1:0]  store_q [DIGITS];
  logic [REF_W-1:0]  ref_el_q, ref_el_d, ref_inc;
  logic [SCAN_W-1:0] scan_el_q, scan_el_d, scan_inc;
  logic [NIB_W-1:0]  key_q, key_d, rise_q, rise_d, fall_q, fall_d;
  logic              accept, is_tick, ref_fire, scan_fire;

  assign in_i.ready = q_ready_i;
  assign accept     = in_i.valid & q_ready_i;
  assign is_tick    = (in_i.opcode == OP_TICK);

  always_comb begin
    ref_inc   = (ref_el_q == '1) ? ref_el_q : ref_el_q + 1'b1;
    scan_inc  = (scan_el_q == '1) ? scan_el_q : scan_el_q + 1'b1;
    ref_fire  = is_tick && (ref_inc >= refresh_period_q);
    scan_fire = is_tick && (scan_inc >= scan_period_q);

    digit_turn_d = digit_turn_q;
    sel_d        = sel_q;
    seg_d        = seg_q;
    ref_el_d     = ref_el_q;
    scan_el_d    = scan_el_q;
    key_d        = key_q;
    rise_d       = rise_q;
    fall_d       = fall_q;

    if (is_tick) begin
      ref_el_d  = ref_fire ? '0 : ref_inc;
      scan_el_d = scan_fire ? '0 : scan_inc;
    end
    if (ref_fire) begin
      sel_d[SEG_W-1:NIB_W] = ONE_NIB << digit_turn_q;
      seg_d                = store_q[digit_turn_q];
      digit_turn_d         = digit_turn_q + 1'b1;
    end
    if (scan_fire) begin
      sel_d[NIB_W-1:0] = ROW_LAST;
      key_d  = in_i.key_levels;
      rise_d = in_i.key_levels & ~key_q;
      fall_d = key_q & ~in_i.key_levels;
    end

    q_cmd_o.refresh = ref_fire;
    q_cmd_o.scan    = scan_fire;
    q_cmd_o.dig_nib = sel_d[SEG_W-1:NIB_W];
    q_cmd_o.row_nib = sel_q[NIB_W-1:0];
    q_cmd_o.seg     = seg_d;
    q_cmd_o.rise    = rise_d;
    q_cmd_o.fall    = fall_d;
  end

  assign q_push_o = accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      refresh_period_q <= REFRESH_RESET;
      scan_period_q    <= SCAN_RESET;
      digit_turn_q     <= '0;
      sel_q            <= '0;
      seg_q            <= '0;
      ref_el_q         <= '0;
      scan_el_q        <= '0;
      key_q            <= '0;
      rise_q           <= '0;
      fall_q           <= '0;
      for (int i = 0; i < DIGITS; i++) store_q[i] <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_REFRESH_PERIOD: refresh_period_q <= cfg_data_i[REF_W-1:0];
          CFG_SCAN_PERIOD:    scan_period_q    <= cfg_data_i[SCAN_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        digit_turn_q <= digit_turn_d;
        sel_q        <= sel_d;
        seg_q        <= seg_d;
        ref_el_q     <= ref_el_d;
        scan_el_q    <= scan_el_d;
        key_q        <= key_d;
        rise_q       <= rise_d;
        fall_q       <= fall_d;
        if (!is_tick) store_q[in_i.digit_index] <= in_i.segment_pattern;
      end
    end
  end

endmodule

[hw/rtl/mdks_queue.sv]
// Two-entry command queue between front and back.
module mdks_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mdks_pkg::cmd_t cmd_i,
  output logic           ready_o,
  input  logic           pop_i,
  output logic           avail_o,
  output mdks_pkg::cmd_t cmd_o
);
  import mdks_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign ready_o = (cnt_q != 2'd2);
  assign avail_o = (cnt_q != 2'd0);
  assign cmd_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

[hw/rtl/mdks_back.sv]
// Back end: expands each command into its result items.
module mdks_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           avail_i,
  input  mdks_pkg::cmd_t cmd_i,
  output logic           pop_o,
  mdks_out_if.source     out_o
);
  import mdks_pkg::*;

  logic [STEP_W-1:0] step_q, nres, last_step;
  logic [NIB_W-1:0]  row;
  logic [1:0]        row_idx;
  logic              load, is_last, fv;
  logic [SEG_W-1:0]  sel, seg;

  logic              valid_q, fv_q, last_q;
  logic [SEG_W-1:0]  sel_q, seg_q;
  logic [NIB_W-1:0]  rise_q, fall_q;

  always_comb begin
    nres      = {2'b0, cmd_i.refresh} + (cmd_i.scan ? STEP_W'(4) : STEP_W'(0));
    last_step = (nres == '0) ? '0 : nres - 1'b1;
    is_last   = (step_q == last_step);
    row_idx   = 2'(step_q - {2'b0, cmd_i.refresh});
    row       = ONE_NIB << row_idx;
    fv        = cmd_i.refresh | cmd_i.scan;
    if (!fv) begin
      sel = '0;
      seg = '0;
    end else if (cmd_i.refresh && step_q == '0) begin
      sel = {cmd_i.dig_nib, cmd_i.row_nib};
      seg = cmd_i.seg;
    end else begin
      sel = {cmd_i.dig_nib, row};
      seg = cmd_i.seg;
    end
  end

  assign load  = avail_i && (!valid_q || out_o.ready);
  assign pop_o = load && is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      step_q  <= '0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        step_q  <= is_last ? '0 : step_q + 1'b1;
      end else if (out_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      fv_q   <= fv;
      sel_q  <= sel;
      seg_q  <= seg;
      last_q <= is_last;
      rise_q <= cmd_i.rise;
      fall_q <= cmd_i.fall;
    end
  end

  assign out_o.valid        = valid_q;
  assign out_o.frame_valid  = fv_q;
  assign out_o.select_byte  = sel_q;
  assign out_o.segment_byte = seg_q;
  assign out_o.last         = last_q;
  assign out_o.key_rise     = rise_q;
  assign out_o.key_fall     = fall_q;

endmodule

[hw/rtl/mux_display_key_scanner.sv]
// Four-digit multiplexed display and four-key matrix scanner, top level.
//
// Each item is either a segment write (opcode 1) or a one-millisecond tick
// (opcode 0). A tick may emit a refresh frame for the next digit once the
// refresh period has run out, and four row-select frames once the scan period
// has run out; key levels on that tick give rise/fall flags held until the
// next scan. Any other item gives one result with frame_valid low. Results
// carry last on the final one of their item. The front end accepts one item a
// cycle, while the queue has room, into a two-entry command queue; the back
// end emits one result a cycle, while out_o is ready, via an output register;
// an item yields one to five results, counted by its step counter. Periods are
// written through the cfg port while idle; the user must see to it: index 0
// refresh period (8 bit, reset 5 ms), index 1 scan period (16 bit, reset 50 ms).
module mux_display_key_scanner (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  mdks_in_if.sink                        in_i,
  mdks_out_if.source                     out_o,
  input  logic                           cfg_we_i,
  input  logic [mdks_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [mdks_pkg::CFG_W-1:0]     cfg_data_i
);
  import mdks_pkg::*;

  cmd_t push_cmd, head_cmd;
  logic push, q_ready, pop, avail;

  // classify and update state
  mdks_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .q_ready_i  (q_ready),
    .q_push_o   (push),
    .q_cmd_o    (push_cmd)
  );

  // decouples front from back-pressure
  mdks_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .ready_o (q_ready),
    .pop_i   (pop),
    .avail_o (avail),
    .cmd_o   (head_cmd)
  );

  // frame expansion
  mdks_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .avail_i (avail),
    .cmd_i   (head_cmd),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule
